// ===== sv/lpfe_pkg.sv =====
package lpfe_pkg;

  // Field widths
  localparam int BYTE_W = 8;
  localparam int LEN_W  = 10;
  localparam int ACC_W  = 14;
  localparam int CNT_W  = 3;
  localparam int PROD_W = ACC_W + 4;

  // Frame format
  localparam logic [LEN_W-1:0] MAX_PAYLOAD   = 10'd512;
  localparam logic [CNT_W-1:0] LENGTH_DIGITS = 3'd4;
  localparam logic [ACC_W-1:0] ACC_CAP       = 14'h3FFF;
  localparam logic [BYTE_W-1:0] ASCII_ZERO   = 8'h30;
  localparam logic [BYTE_W-1:0] ASCII_NINE   = 8'h39;

  // Register reset values
  localparam logic [BYTE_W-1:0] HEADER_RST    = 8'd0;
  localparam logic [LEN_W-1:0]  MAX_LEN_RST   = 10'd512;
  localparam logic              END_CHECK_RST = 1'b1;
  localparam logic [BYTE_W-1:0] END_BYTE_RST  = 8'd125;

  // Register map, indexed by paddr[3:2]
  typedef enum logic [1:0] {
    REG_HEADER    = 2'd0,
    REG_MAX_LEN   = 2'd1,
    REG_END_CHECK = 2'd2,
    REG_END_BYTE  = 2'd3
  } reg_idx_t;

  typedef enum logic [1:0] {
    ST_OK         = 2'd0,
    ST_BAD_DIGIT  = 2'd1,
    ST_TOO_LONG   = 2'd2,
    ST_END_BAD    = 2'd3
  } frame_status_t;

  typedef enum logic [2:0] {
    PH_HUNT = 3'b001,
    PH_LEN  = 3'b010,
    PH_DATA = 3'b100
  } phase_t;

  typedef struct packed {
    logic [BYTE_W-1:0] header_byte;
    logic [LEN_W-1:0]  max_payload_length;
    logic              end_check_enable;
    logic [BYTE_W-1:0] end_byte;
  } cfg_t;

  typedef struct packed {
    logic [BYTE_W-1:0] payload_byte;
    logic              data_valid;
    logic              frame_last;
    frame_status_t     frame_status;
  } res_t;

endpackage

// ===== sv/lpfe_parser.sv =====
module lpfe_parser (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          accept,
  input  logic [lpfe_pkg::BYTE_W-1:0]   rx_byte,
  input  lpfe_pkg::cfg_t                cfg,
  output lpfe_pkg::res_t                result,
  output logic                          has_result
);

  lpfe_pkg::phase_t                phase, phase_next;
  logic [lpfe_pkg::CNT_W-1:0]      digit_count, digit_count_next;
  logic [lpfe_pkg::ACC_W-1:0]      length_accumulator, length_accumulator_next;
  logic [lpfe_pkg::LEN_W-1:0]      bytes_left, bytes_left_next;

  logic                            is_digit;
  logic [3:0]                      digit;
  logic [lpfe_pkg::PROD_W-1:0]     acc_wide, prod;
  logic [lpfe_pkg::ACC_W-1:0]      acc_sat;
  logic [lpfe_pkg::CNT_W-1:0]      cnt_inc;
  logic [lpfe_pkg::LEN_W-1:0]      limit, left_dec;

  // Digit decode and saturating acc*10 + digit
  always_comb begin
    is_digit = (rx_byte >= lpfe_pkg::ASCII_ZERO) && (rx_byte <= lpfe_pkg::ASCII_NINE);
    digit    = 4'(rx_byte - lpfe_pkg::ASCII_ZERO);
    acc_wide = lpfe_pkg::PROD_W'(length_accumulator);
    prod     = (acc_wide << 3) + (acc_wide << 1) + lpfe_pkg::PROD_W'(digit);
    acc_sat  = (prod > lpfe_pkg::PROD_W'(lpfe_pkg::ACC_CAP)) ? lpfe_pkg::ACC_CAP
                                                           : prod[lpfe_pkg::ACC_W-1:0];
    cnt_inc  = digit_count + 3'd1;
    limit    = (cfg.max_payload_length < lpfe_pkg::MAX_PAYLOAD) ? cfg.max_payload_length
                                                                : lpfe_pkg::MAX_PAYLOAD;
    left_dec = bytes_left - 10'd1;
  end

  // One step of the framing state machine per byte
  always_comb begin
    phase_next              = phase;
    digit_count_next        = digit_count;
    length_accumulator_next = length_accumulator;
    bytes_left_next         = bytes_left;
    result                  = '0;
    has_result              = 1'b0;
    unique case (phase)
      lpfe_pkg::PH_LEN: begin
        if (!is_digit) begin
          phase_next              = lpfe_pkg::PH_HUNT;
          digit_count_next        = '0;
          length_accumulator_next = '0;
          result.frame_last       = 1'b1;
          result.frame_status     = lpfe_pkg::ST_BAD_DIGIT;
          has_result              = 1'b1;
        end else begin
          length_accumulator_next = acc_sat;
          digit_count_next        = cnt_inc;
          if (cnt_inc >= lpfe_pkg::LENGTH_DIGITS) begin
            digit_count_next = '0;
            if (acc_sat > lpfe_pkg::ACC_W'(limit)) begin
              phase_next              = lpfe_pkg::PH_HUNT;
              length_accumulator_next = '0;
              result.frame_last       = 1'b1;
              result.frame_status     = lpfe_pkg::ST_TOO_LONG;
              has_result              = 1'b1;
            end else if (acc_sat == '0) begin
              // empty frame: no end byte to check
              phase_next          = lpfe_pkg::PH_HUNT;
              result.frame_last   = 1'b1;
              result.frame_status = cfg.end_check_enable ? lpfe_pkg::ST_END_BAD
                                                         : lpfe_pkg::ST_OK;
              has_result          = 1'b1;
            end else begin
              bytes_left_next         = acc_sat[lpfe_pkg::LEN_W-1:0];
              length_accumulator_next = '0;
              phase_next              = lpfe_pkg::PH_DATA;
            end
          end
        end
      end
      lpfe_pkg::PH_DATA: begin
        bytes_left_next     = left_dec;
        result.payload_byte = rx_byte;
        result.data_valid   = 1'b1;
        has_result          = 1'b1;
        if (left_dec == '0) begin
          result.frame_last = 1'b1;
          if (cfg.end_check_enable && (rx_byte != cfg.end_byte)) begin
            result.frame_status = lpfe_pkg::ST_END_BAD;
          end
          phase_next = lpfe_pkg::PH_HUNT;
        end
      end
      default: begin
        phase_next = lpfe_pkg::PH_HUNT;
        if (rx_byte == cfg.header_byte) begin
          phase_next              = lpfe_pkg::PH_LEN;
          digit_count_next        = '0;
          length_accumulator_next = '0;
        end
      end
    endcase
  end

  // State registers, advanced on each accepted beat
  always_ff @(posedge clk) begin
    if (rst) begin
      phase              <= lpfe_pkg::PH_HUNT;
      digit_count        <= '0;
      length_accumulator <= '0;
      bytes_left         <= '0;
    end else if (accept) begin
      phase              <= phase_next;
      digit_count        <= digit_count_next;
      length_accumulator <= length_accumulator_next;
      bytes_left         <= bytes_left_next;
    end
  end

endmodule

// ===== sv/lpfe_out_buf.sv =====
module lpfe_out_buf (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  lpfe_pkg::res_t  item,
  output logic            space,
  output logic            out_valid,
  input  logic            out_ready,
  output lpfe_pkg::res_t  head
);

  logic           main_valid, skid_valid;
  lpfe_pkg::res_t main_item, skid_item;
  logic           pop;

  assign pop       = main_valid && out_ready;
  assign space     = !skid_valid;
  assign out_valid = main_valid;
  assign head      = main_item;

  // Valid flags
  always_ff @(posedge clk) begin
    if (rst) begin
      main_valid <= 1'b0;
      skid_valid <= 1'b0;
    end else if (pop) begin
      if (skid_valid) begin
        skid_valid <= 1'b0;
      end else begin
        main_valid <= push;
      end
    end else if (push) begin
      if (!main_valid) begin
        main_valid <= 1'b1;
      end else begin
        skid_valid <= 1'b1;
      end
    end
  end

  // Payload: skid moves up on a pop, new beat fills the free slot
  always_ff @(posedge clk) begin
    if (pop) begin
      if (skid_valid) begin
        main_item <= skid_item;
      end else if (push) begin
        main_item <= item;
      end
    end else if (push) begin
      if (!main_valid) begin
        main_item <= item;
      end else begin
        skid_item <= item;
      end
    end
  end

endmodule

// ===== sv/length_prefixed_frame_extractor.sv =====
// Length-prefixed frame extractor. Takes one received byte per beat and
// finds frames of the form header byte, four ASCII decimal length digits,
// then that many payload bytes. Each payload byte comes out as one result,
// the last one marked with frame_last; a bad length digit, an over-long
// length or (with the end check on) a wrong or missing final byte is
// reported in frame_status. A byte is taken every cycle while in_ready
// is high, and its result, if any, is registered. Results sit in a
// two-entry output buffer, so in_ready drops only while both entries are
// held by a stalled sink. Registers on the APB port (byte address 4*i):
// header_byte, max_payload_length, end_check_enable, end_byte; write them
// only while no frame is in flight.
module length_prefixed_frame_extractor (
  input  logic                          clk,
  input  logic                          rst,
  // byte stream in
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [lpfe_pkg::BYTE_W-1:0]   rx_byte,
  // results out
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [lpfe_pkg::BYTE_W-1:0]   payload_byte,
  output logic                          data_valid,
  output logic                          frame_last,
  output logic [1:0]                    frame_status,
  // configuration
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [3:0]                    paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);

  lpfe_pkg::cfg_t     cfg;
  lpfe_pkg::res_t     result, head;
  lpfe_pkg::reg_idx_t reg_sel;
  logic               accept, has_result, space, cfg_wr;

  assign reg_sel = lpfe_pkg::reg_idx_t'(paddr[3:2]);
  assign cfg_wr  = psel && penable && pwrite;
  assign pready  = 1'b1;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.header_byte        <= lpfe_pkg::HEADER_RST;
      cfg.max_payload_length <= lpfe_pkg::MAX_LEN_RST;
      cfg.end_check_enable   <= lpfe_pkg::END_CHECK_RST;
      cfg.end_byte           <= lpfe_pkg::END_BYTE_RST;
    end else if (cfg_wr) begin
      unique case (reg_sel)
        lpfe_pkg::REG_HEADER:    cfg.header_byte        <= pwdata[lpfe_pkg::BYTE_W-1:0];
        lpfe_pkg::REG_MAX_LEN:   cfg.max_payload_length <= pwdata[lpfe_pkg::LEN_W-1:0];
        lpfe_pkg::REG_END_CHECK: cfg.end_check_enable   <= pwdata[0];
        lpfe_pkg::REG_END_BYTE:  cfg.end_byte           <= pwdata[lpfe_pkg::BYTE_W-1:0];
        default: ;
      endcase
    end
  end

  // Read-back
  always_comb begin
    unique case (reg_sel)
      lpfe_pkg::REG_HEADER:    prdata = 32'(cfg.header_byte);
      lpfe_pkg::REG_MAX_LEN:   prdata = 32'(cfg.max_payload_length);
      lpfe_pkg::REG_END_CHECK: prdata = 32'(cfg.end_check_enable);
      lpfe_pkg::REG_END_BYTE:  prdata = 32'(cfg.end_byte);
      default:                 prdata = '0;
    endcase
  end

  assign in_ready = space;
  assign accept   = in_valid && in_ready;

  lpfe_parser u_parser (
    .clk        (clk),
    .rst        (rst),
    .accept     (accept),
    .rx_byte    (rx_byte),
    .cfg        (cfg),
    .result     (result),
    .has_result (has_result)
  );

  lpfe_out_buf u_out_buf (
    .clk       (clk),
    .rst       (rst),
    .push      (accept && has_result),
    .item      (result),
    .space     (space),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .head      (head)
  );

  assign payload_byte = head.payload_byte;
  assign data_valid   = head.data_valid;
  assign frame_last   = head.frame_last;
  assign frame_status = head.frame_status;

endmodule

// ===== sv/lpfe_checker.sv =====
module lpfe_checker (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_ready,
  input logic [7:0]  payload_byte,
  input logic        data_valid,
  input logic        frame_last,
  input logic [1:0]  frame_status,
  input logic        pready
);

  // a result without data is always a frame end or an error
  a_nodata_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && !data_valid |-> frame_last)
    else $error("result without data not marked last");

  // status only on the last result of a frame
  a_status_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && !frame_last |-> frame_status == lpfe_pkg::ST_OK)
    else $error("non-zero status on a mid-frame beat");

  // error results carry a zero byte
  a_nodata_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !data_valid |-> payload_byte == 8'd0)
    else $error("error result carries payload data");

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(payload_byte) && $stable(frame_last))
    else $error("stalled result changed");

  a_pready: assert property (@(posedge clk) disable iff (rst) pready)
    else $error("pready low");

endmodule

bind length_prefixed_frame_extractor lpfe_checker u_lpfe_checker (
  .clk          (clk),
  .rst          (rst),
  .out_valid    (out_valid),
  .out_ready    (out_ready),
  .payload_byte (payload_byte),
  .data_valid   (data_valid),
  .frame_last   (frame_last),
  .frame_status (frame_status),
  .pready       (pready)
);

// ===== tb/tb_length_prefixed_frame_extractor.sv =====
`timescale 1ns / 100ps

module tb_length_prefixed_frame_extractor;

  localparam int DRAIN_LIMIT = 20000;

  logic                        clk;
  logic                        rst;
  logic                        in_valid;
  logic                        in_ready;
  logic [lpfe_pkg::BYTE_W-1:0] rx_byte;
  logic                        out_valid;
  logic                        out_ready;
  logic [lpfe_pkg::BYTE_W-1:0] payload_byte;
  logic                        data_valid;
  logic                        frame_last;
  logic [1:0]                  frame_status;
  logic                        psel;
  logic                        penable;
  logic                        pwrite;
  logic [3:0]                  paddr;
  logic [31:0]                 pwdata;
  logic [31:0]                 prdata;
  logic                        pready;

  length_prefixed_frame_extractor i_dut (.*);

  // Extractor state as the testbench sees it
  lpfe_pkg::cfg_t             cfg;
  lpfe_pkg::phase_t           fx_phase;
  logic [lpfe_pkg::CNT_W-1:0] fx_digits;
  logic [lpfe_pkg::ACC_W-1:0] fx_acc;
  logic [lpfe_pkg::LEN_W-1:0] fx_left;
  lpfe_pkg::res_t             frame_out_q[$];

  bit idle_en    = 1'b0;
  int sink_hold  = 0;
  int n_bytes    = 0;
  int n_results  = 0;
  int n_ends     = 0;
  int n_flagged  = 0;
  int n_settings = 1;
  int n_mismatch = 0;

  // Clock
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Hard stop
  initial begin
    #(20_000_000);
    $display("Timed out with %0d results still pending", frame_out_q.size());
    $display("FAILURE");
    $finish;
  end

  // Length limit in force: register or build limit, whichever is smaller
  function automatic logic [lpfe_pkg::LEN_W-1:0] len_limit();
    return (cfg.max_payload_length < lpfe_pkg::MAX_PAYLOAD) ? cfg.max_payload_length
                                                            : lpfe_pkg::MAX_PAYLOAD;
  endfunction

  // Advance the frame state by one byte; returns 1 when a result is due
  function automatic bit frame_step(input logic [lpfe_pkg::BYTE_W-1:0] b,
                                    output lpfe_pkg::res_t r);
    int sum;
    r = '0;
    case (fx_phase)
      lpfe_pkg::PH_LEN: begin
        if (b < lpfe_pkg::ASCII_ZERO || b > lpfe_pkg::ASCII_NINE) begin
          fx_phase       = lpfe_pkg::PH_HUNT;
          fx_digits      = '0;
          fx_acc         = '0;
          r.frame_last   = 1'b1;
          r.frame_status = lpfe_pkg::ST_BAD_DIGIT;
          return 1'b1;
        end
        // saturating decimal accumulate
        sum       = int'(fx_acc) * 10 + int'(b - lpfe_pkg::ASCII_ZERO);
        fx_acc    = (sum > int'(lpfe_pkg::ACC_CAP)) ? lpfe_pkg::ACC_CAP
                                                    : sum[lpfe_pkg::ACC_W-1:0];
        fx_digits = fx_digits + 1'b1;
        if (fx_digits < lpfe_pkg::LENGTH_DIGITS) return 1'b0;
        fx_digits = '0;
        if (fx_acc > len_limit()) begin
          fx_phase       = lpfe_pkg::PH_HUNT;
          fx_acc         = '0;
          r.frame_last   = 1'b1;
          r.frame_status = lpfe_pkg::ST_TOO_LONG;
          return 1'b1;
        end
        // empty frame: nothing to carry an end byte
        if (fx_acc == '0) begin
          fx_phase       = lpfe_pkg::PH_HUNT;
          r.frame_last   = 1'b1;
          r.frame_status = cfg.end_check_enable ? lpfe_pkg::ST_END_BAD : lpfe_pkg::ST_OK;
          return 1'b1;
        end
        fx_left  = fx_acc[lpfe_pkg::LEN_W-1:0];
        fx_acc   = '0;
        fx_phase = lpfe_pkg::PH_DATA;
        return 1'b0;
      end
      lpfe_pkg::PH_DATA: begin
        fx_left        = fx_left - 1'b1;
        r.payload_byte = b;
        r.data_valid   = 1'b1;
        if (fx_left == '0) begin
          r.frame_last = 1'b1;
          if (cfg.end_check_enable && b != cfg.end_byte) r.frame_status = lpfe_pkg::ST_END_BAD;
          fx_phase = lpfe_pkg::PH_HUNT;
        end
        return 1'b1;
      end
      default: begin
        fx_phase = lpfe_pkg::PH_HUNT;
        if (b == cfg.header_byte) begin
          fx_phase  = lpfe_pkg::PH_LEN;
          fx_digits = '0;
          fx_acc    = '0;
        end
        return 1'b0;
      end
    endcase
  endfunction

  task automatic note_mismatch(input string what);
    n_mismatch++;
    if (n_mismatch <= 10) $display("%0t: mismatch, %s", $time, what);
  endtask

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) note_mismatch($sformatf("%s expected %h, got %h", name, want, got));
  endtask

  // Result checker: sampled mid-cycle, a beat moves on the next rising edge
  always @(negedge clk) begin : check_results
    lpfe_pkg::res_t got;
    lpfe_pkg::res_t want;
    if (!rst && out_valid && out_ready) begin
      got = {payload_byte, data_valid, frame_last, frame_status};
      n_results++;
      if (got.frame_last) n_ends++;
      if (got.frame_status != lpfe_pkg::ST_OK) n_flagged++;
      if (frame_out_q.size() == 0) begin
        note_mismatch($sformatf("result with nothing pending: byte %h valid %b last %b st %h",
                                payload_byte, data_valid, frame_last, frame_status));
      end else begin
        want = frame_out_q.pop_front();
        check_field("payload_byte", 32'(want.payload_byte), 32'(got.payload_byte));
        check_field("data_valid", 32'(want.data_valid), 32'(got.data_valid));
        check_field("frame_last", 32'(want.frame_last), 32'(got.frame_last));
        check_field("frame_status", 32'(want.frame_status), 32'(got.frame_status));
      end
    end
  end

  // Sink side: random stall bursts
  always @(posedge clk) begin
    if (sink_hold > 0) begin
      sink_hold <= sink_hold - 1;
      out_ready <= 1'b0;
    end else if (idle_en && $urandom_range(0, 11) == 0) begin
      sink_hold <= $urandom_range(0, 16);
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // One byte beat; in_valid stays high on return so the next beat can follow
  task automatic send_byte(input logic [lpfe_pkg::BYTE_W-1:0] b);
    bit             taken;
    lpfe_pkg::res_t r;
    if (idle_en && $urandom_range(0, 9) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk);
    end
    in_valid <= 1'b1;
    rx_byte  <= b;
    do begin
      @(negedge clk);
      taken = in_ready;
      @(posedge clk);
    end while (!taken);
    n_bytes++;
    if (frame_step(b, r)) frame_out_q.push_back(r);
  endtask

  // Drop valid and hold off until every pending result has come out or the drain limit runs out
  task automatic wait_drained();
    int n = 0;
    in_valid <= 1'b0;
    do begin
      @(posedge clk);
      n++;
    end while (frame_out_q.size() != 0 && n < DRAIN_LIMIT);
  endtask

  task automatic send_header_length(input int len);
    send_byte(cfg.header_byte);
    for (int p = 1000; p >= 1; p /= 10)
      send_byte(lpfe_pkg::ASCII_ZERO + 8'((len / p) % 10));
  endtask

  task automatic send_frame(input int len, input bit good_end);
    send_header_length(len);
    for (int i = 0; i < len; i++) begin
      if (i == len - 1 && good_end) send_byte(cfg.end_byte);
      else send_byte(8'($urandom_range(0, 255)));
    end
  endtask

  // APB access: setup cycle, then access until pready
  task automatic apb_access(input lpfe_pkg::reg_idx_t idx, input bit wr,
                            input logic [31:0] wdata, output logic [31:0] rdata);
    bit done;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= {idx, 2'b00};
    pwdata  <= wdata;
    @(posedge clk);
    penable <= 1'b1;
    do begin
      @(negedge clk);
      done  = pready;
      rdata = prdata;
      @(posedge clk);
    end while (!done);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  task automatic check_reg(input lpfe_pkg::reg_idx_t idx);
    logic [31:0] rd;
    logic [31:0] want;
    case (idx)
      lpfe_pkg::REG_HEADER:    want = 32'(cfg.header_byte);
      lpfe_pkg::REG_MAX_LEN:   want = 32'(cfg.max_payload_length);
      lpfe_pkg::REG_END_CHECK: want = 32'(cfg.end_check_enable);
      default:                 want = 32'(cfg.end_byte);
    endcase
    apb_access(idx, 1'b0, 32'd0, rd);
    check_field($sformatf("register %s", idx.name()), want, rd);
  endtask

  task automatic write_reg(input lpfe_pkg::reg_idx_t idx, input logic [31:0] val);
    logic [31:0] scratch;
    apb_access(idx, 1'b1, val, scratch);
    case (idx)
      lpfe_pkg::REG_HEADER:    cfg.header_byte        = val[lpfe_pkg::BYTE_W-1:0];
      lpfe_pkg::REG_MAX_LEN:   cfg.max_payload_length = val[lpfe_pkg::LEN_W-1:0];
      lpfe_pkg::REG_END_CHECK: cfg.end_check_enable   = val[0];
      default:                 cfg.end_byte           = val[lpfe_pkg::BYTE_W-1:0];
    endcase
    check_reg(idx);
  endtask

  // Finish any open frame, let results drain, then reprogram all registers
  task automatic apply_config(input int hdr, input int max_len, input bit chk, input int eb);
    while (fx_phase != lpfe_pkg::PH_HUNT)
      send_byte(fx_phase == lpfe_pkg::PH_LEN ? 8'h2F : 8'($urandom_range(0, 255)));
    wait_drained();
    repeat (4) @(posedge clk);
    write_reg(lpfe_pkg::REG_HEADER, hdr);
    write_reg(lpfe_pkg::REG_MAX_LEN, max_len);
    write_reg(lpfe_pkg::REG_END_CHECK, 32'(chk));
    write_reg(lpfe_pkg::REG_END_BYTE, eb);
    n_settings++;
  endtask

  // Registers read back their reset values
  task automatic test_reset_state();
    check_reg(lpfe_pkg::REG_HEADER);
    check_reg(lpfe_pkg::REG_MAX_LEN);
    check_reg(lpfe_pkg::REG_END_CHECK);
    check_reg(lpfe_pkg::REG_END_BYTE);
  endtask

  // Hand-picked frames under the reset settings
  task automatic test_directed_frames();
    idle_en = 1'b1;
    send_frame(1, 1'b1);
    // extreme data bytes, header value as data, wrong closing byte
    send_header_length(3);
    send_byte(8'hFF);
    send_byte(cfg.header_byte);
    send_byte(8'h7B);
    // digits just outside the ASCII range, and a header in the length
    send_byte(cfg.header_byte);
    send_byte(8'h2F);
    send_byte(cfg.header_byte);
    send_byte(8'h39);
    send_byte(8'h3A);
    send_byte(cfg.header_byte);
    send_byte(cfg.header_byte);
    // empty frame with end check on, then the largest length
    send_header_length(0);
    send_header_length(9999);
  endtask

  // Limit of one, end check off, extreme header and end byte
  task automatic test_register_extremes();
    apply_config(255, 1, 1'b0, 0);
    send_frame(1, 1'b1);
    send_header_length(2);
    send_header_length(0);
    send_frame(1, 1'b0);
  endtask

  // Register limit above the build limit; a digit as header
  task automatic test_long_frame_limit();
    apply_config(int'(lpfe_pkg::ASCII_ZERO) + 7, 1023, 1'b1, 255);
    send_frame(512, 1'b1);
    send_header_length(513);
    send_frame(3, 1'b0);
  endtask

  // Mostly well-formed frames with random content, plus noise and broken frames
  task automatic test_random_stream();
    int          start;
    int          kind;
    int          len;
    int          lim;
    int          max_len;
    int          hdr;
    logic [7:0]  nd;
    for (int seg = 0; seg < 5; seg++) begin
      idle_en = (seg < 4);
      case ($urandom_range(0, 5))
        0:       max_len = 1;
        1:       max_len = 512;
        2:       max_len = 1023;
        3:       max_len = 0;
        default: max_len = $urandom_range(1, 600);
      endcase
      hdr = ($urandom_range(0, 4) == 0) ? 48 + $urandom_range(0, 9) : $urandom_range(0, 255);
      apply_config(hdr, max_len, 1'($urandom_range(0, 1)), $urandom_range(0, 255));
      lim   = int'(len_limit());
      start = n_bytes;
      while (n_bytes - start < 180) begin
        kind = $urandom_range(0, 99);
        if (kind < 70) begin
          if ($urandom_range(0, 39) == 0) len = $urandom_range(0, lim);
          else len = $urandom_range(0, (lim < 24) ? lim : 24);
          send_frame(len, $urandom_range(0, 4) != 0);
        end else if (kind < 80) begin
          repeat ($urandom_range(1, 8)) send_byte(8'($urandom_range(0, 255)));
        end else if (kind < 88) begin
          // length cut short by a non-digit
          send_byte(cfg.header_byte);
          repeat ($urandom_range(0, 3))
            send_byte(lpfe_pkg::ASCII_ZERO + 8'($urandom_range(0, 9)));
          do nd = 8'($urandom_range(0, 255));
          while (nd >= lpfe_pkg::ASCII_ZERO && nd <= lpfe_pkg::ASCII_NINE);
          send_byte(nd);
        end else if (kind < 94) begin
          send_header_length($urandom_range(lim + 1, 9999));
        end else begin
          // payload cut short; following bytes are taken as payload
          len = $urandom_range(1, 24);
          send_header_length(len);
          repeat ($urandom_range(0, len - 1)) send_byte(8'($urandom_range(0, 255)));
        end
        if (idle_en && $urandom_range(0, 49) == 0) wait_drained();
        if (seg < 4 && $urandom_range(0, 63) == 0) idle_en = !idle_en;
      end
    end
  endtask

  initial begin
    rst       = 1'b1;
    in_valid  = 1'b0;
    rx_byte   = '0;
    out_ready = 1'b0;
    psel      = 1'b0;
    penable   = 1'b0;
    pwrite    = 1'b0;
    paddr     = '0;
    pwdata    = '0;
    cfg       = {lpfe_pkg::HEADER_RST, lpfe_pkg::MAX_LEN_RST, lpfe_pkg::END_CHECK_RST,
                 lpfe_pkg::END_BYTE_RST};
    fx_phase  = lpfe_pkg::PH_HUNT;
    fx_digits = '0;
    fx_acc    = '0;
    fx_left   = '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_reset_state();
    test_directed_frames();
    test_register_extremes();
    test_long_frame_limit();
    test_random_stream();

    // drain, then let the last results leave the output buffer
    wait_drained();
    repeat (8) @(posedge clk);
    if (frame_out_q.size() != 0) begin
      n_mismatch += frame_out_q.size();
      $display("%0d results never arrived", frame_out_q.size());
    end
    $display("Streamed %0d bytes under %0d register settings, with gaps and stalls on both sides",
             n_bytes, n_settings);
    $display("Checked %0d results: %0d frame or error ends, %0d with a non-ok status, %0d bad",
             n_results, n_ends, n_flagged, n_mismatch);
    if (n_mismatch == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
